### rtl/core/wave_leapfrog_stencil_3d_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef WAVE_LEAPFROG_STENCIL_3D_TOP_DEFINES_SVH
`define WAVE_LEAPFROG_STENCIL_3D_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define WLS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wls3d: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define WLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wls3d: next-cycle check failed");

`endif

### rtl/core/wls3d_pkg.sv
package wls3d_pkg;

  localparam int MAX_DIM  = 16;
  localparam int DIM_W    = 5;
  localparam int POS_W    = 4;
  localparam int ADDR_W   = 12;
  localparam int NODES    = 4096;
  localparam int CNT_W    = 13;
  localparam int STRIDE_W = 9;
  localparam int WORD_W   = 32;
  localparam int COEF_W   = 32;
  localparam int PADDR_W  = 5;
  localparam logic [COEF_W-1:0] COEF_ONE = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_STEP = 2'd1,
    ACT_READ = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    REG_DIM_X  = 3'd0,
    REG_DIM_Y  = 3'd1,
    REG_DIM_Z  = 3'd2,
    REG_COEF_X = 3'd3,
    REG_COEF_Y = 3'd4,
    REG_COEF_Z = 3'd5,
    REG_PROBE  = 3'd6
  } reg_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [ADDR_W-1:0]        node;
    logic signed [WORD_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0]    nx;
    logic [DIM_W-1:0]    ny;
    logic [DIM_W-1:0]    nz;
    logic [STRIDE_W-1:0] nxny;
    logic [CNT_W-1:0]    ncount;
    logic [COEF_W-1:0]   coef_x;
    logic [COEF_W-1:0]   coef_y;
    logic [COEF_W-1:0]   coef_z;
    logic [ADDR_W-1:0]   probe;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDW,
    ST_PRB,
    ST_PRW,
    ST_EMIT,
    ST_NODE,
    ST_FETCH,
    ST_MUL,
    ST_ACC,
    ST_WB,
    ST_ADV,
    ST_SQR,
    ST_SQD,
    ST_SQM,
    ST_SQA
  } st_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    if (d < DIM_W'(2)) return DIM_W'(2);
    if (d > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return d;
  endfunction

endpackage

### rtl/core/wls3d_regs.sv
module wls3d_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wls3d_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output wls3d_pkg::cfg_t               cfg
);
  import wls3d_pkg::*;

  logic [DIM_W-1:0]  dim_x, dim_y, dim_z;
  logic [COEF_W-1:0] coef_x, coef_y, coef_z;
  logic [ADDR_W-1:0] probe_node;
  logic [COEF_W-1:0] coef_sat;
  logic              wr;
  reg_t              sel;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign sel      = reg_t'(paddr[PADDR_W-1:2]);
  assign coef_sat = (pwdata > COEF_ONE) ? COEF_ONE : pwdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x      <= DIM_W'(MAX_DIM);
      dim_y      <= DIM_W'(MAX_DIM);
      dim_z      <= DIM_W'(MAX_DIM);
      coef_x     <= '0;
      coef_y     <= '0;
      coef_z     <= '0;
      probe_node <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_DIM_X:  dim_x      <= pwdata[DIM_W-1:0];
        REG_DIM_Y:  dim_y      <= pwdata[DIM_W-1:0];
        REG_DIM_Z:  dim_z      <= pwdata[DIM_W-1:0];
        REG_COEF_X: coef_x     <= coef_sat;
        REG_COEF_Y: coef_y     <= coef_sat;
        REG_COEF_Z: coef_z     <= coef_sat;
        REG_PROBE:  probe_node <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_DIM_X:  prdata = 32'(dim_x);
      REG_DIM_Y:  prdata = 32'(dim_y);
      REG_DIM_Z:  prdata = 32'(dim_z);
      REG_COEF_X: prdata = coef_x;
      REG_COEF_Y: prdata = coef_y;
      REG_COEF_Z: prdata = coef_z;
      REG_PROBE:  prdata = 32'(probe_node);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.nx     = eff_dim(dim_x);
    cfg.ny     = eff_dim(dim_y);
    cfg.nz     = eff_dim(dim_z);
    cfg.nxny   = STRIDE_W'(cfg.nx) * STRIDE_W'(cfg.ny);
    cfg.ncount = CNT_W'(cfg.nxny) * CNT_W'(cfg.nz);
    cfg.coef_x = coef_x;
    cfg.coef_y = coef_y;
    cfg.coef_z = coef_z;
    cfg.probe  = probe_node;
  end

endmodule

### rtl/core/wls3d_front.sv
module wls3d_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic [wls3d_pkg::ADDR_W-1:0]        node,
  input  logic signed [wls3d_pkg::WORD_W-1:0] value,
  output logic                                head_valid,
  output wls3d_pkg::item_t                    head,
  input  logic                                pop
);
  import wls3d_pkg::*;

  item_t      q [2];
  logic [1:0] count;
  logic       wp, rp, push;

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= '{action: action, node: node, value: value};
  end

endmodule

### rtl/core/wls3d_back.sv
module wls3d_back (
  input  logic                                clk,
  input  logic                                rst,
  input  wls3d_pkg::cfg_t                     cfg,
  input  logic                                head_valid,
  input  wls3d_pkg::item_t                    head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wls3d_pkg::WORD_W-1:0] probe_value,
  output logic [wls3d_pkg::WORD_W-1:0]        peak_abs,
  output logic [63:0]                         sum_squares,
  output logic signed [wls3d_pkg::WORD_W-1:0] node_value,
  output logic                                error
);
  import wls3d_pkg::*;

  logic signed [WORD_W-1:0] mem_a [NODES];
  logic signed [WORD_W-1:0] mem_b [NODES];
  logic signed [WORD_W-1:0] dout_a, dout_b, cur_dout, nxt_dout;

  st_t st, st_next;
  logic                     cur_b;
  logic [WORD_W-1:0]        peak;
  logic [63:0]              last_sum, sum;
  logic [POS_W-1:0]         px, py, pz;
  logic [ADDR_W-1:0]        idx;
  logic [3:0]               k;
  logic [1:0]               ax;
  logic signed [WORD_W-1:0] nb [8];
  logic [65:0]              prod;
  logic                     neg;
  logic signed [36:0]       acc;
  logic [WORD_W-1:0]        mag;
  logic [63:0]              sq;
  logic signed [WORD_W-1:0] node_val, probe_val;
  logic                     err;

  logic                     we_a, we_b, emit;
  logic [ADDR_W-1:0]        ra, wa;
  logic signed [WORD_W-1:0] wd;

  logic [CNT_W-1:0]         idx13, xlo, xhi, ylo, yhi, zlo, zhi, oth_x, oth_y, oth_z;
  logic [CNT_W-1:0]         sy, sz;
  logic                     pinned, last_node;
  logic signed [WORD_W-1:0] lo, hi;
  logic [COEF_W-1:0]        coef;
  logic signed [34:0]       d;
  logic [33:0]              dmag;
  logic [34:0]              r;
  logic signed [37:0]       nv;
  logic signed [WORD_W-1:0] nv_sat;
  logic [WORD_W-1:0]        vmag, hmag;
  logic [64:0]              sum_w;

  assign cur_dout = cur_b ? dout_b : dout_a;
  assign nxt_dout = cur_b ? dout_a : dout_b;

  always_ff @(posedge clk) begin
    if (we_a) mem_a[wa] <= wd;
    dout_a <= mem_a[ra];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[wa] <= wd;
    dout_b <= mem_b[ra];
  end

  // Neighbor addresses; on a two-node axis both sides mirror to the other node.
  always_comb begin
    idx13 = CNT_W'(idx);
    sy    = CNT_W'(cfg.nx);
    sz    = CNT_W'(cfg.nxny);
    oth_x = (px == '0) ? idx13 + CNT_W'(1) : idx13 - CNT_W'(1);
    oth_y = (py == '0) ? idx13 + sy : idx13 - sy;
    oth_z = (pz == '0) ? idx13 + sz : idx13 - sz;
    xlo   = (cfg.nx == DIM_W'(2)) ? oth_x : idx13 - CNT_W'(1);
    xhi   = (cfg.nx == DIM_W'(2)) ? oth_x : idx13 + CNT_W'(1);
    ylo   = (cfg.ny == DIM_W'(2)) ? oth_y : idx13 - sy;
    yhi   = (cfg.ny == DIM_W'(2)) ? oth_y : idx13 + sy;
    zlo   = (cfg.nz == DIM_W'(2)) ? oth_z : idx13 - sz;
    zhi   = (cfg.nz == DIM_W'(2)) ? oth_z : idx13 + sz;
    pinned = (cfg.nx > DIM_W'(2) && (px == '0 || DIM_W'(px) == cfg.nx - DIM_W'(1))) ||
             (cfg.ny > DIM_W'(2) && (py == '0 || DIM_W'(py) == cfg.ny - DIM_W'(1))) ||
             (cfg.nz > DIM_W'(2) && (pz == '0 || DIM_W'(pz) == cfg.nz - DIM_W'(1)));
    last_node = (idx13 == cfg.ncount - CNT_W'(1));
  end

  // Axis datapath: d = lo + hi - 2c, magnitude times coefficient.
  always_comb begin
    case (ax)
      2'd0:    begin lo = nb[1]; hi = nb[2]; coef = cfg.coef_x; end
      2'd1:    begin lo = nb[3]; hi = nb[4]; coef = cfg.coef_y; end
      default: begin lo = nb[5]; hi = nb[6]; coef = cfg.coef_z; end
    endcase
    d    = 35'(lo) + 35'(hi) - (35'(nb[0]) <<< 1);
    dmag = 34'(d[34] ? -d : d);
    r    = 35'((prod + (66'd1 << 30)) >> 31);
    nv   = (38'(nb[0]) <<< 1) - 38'(nb[7]) + 38'(acc);
    if (nv > 38'sh7FFF_FFFF)
      nv_sat = 32'sh7FFF_FFFF;
    else if (nv < -38'sh8000_0000)
      nv_sat = 32'sh8000_0000;
    else
      nv_sat = nv[WORD_W-1:0];
    vmag  = head.value[WORD_W-1] ? ~head.value + 32'd1 : head.value;
    hmag  = cur_dout[WORD_W-1] ? ~cur_dout + 32'd1 : cur_dout;
    sum_w = 65'(sum) + 65'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else st <= st_next;
  end

  always_comb begin
    st_next = st;
    pop     = 1'b0;
    we_a    = 1'b0;
    we_b    = 1'b0;
    wa      = idx;
    wd      = '0;
    ra      = idx;
    emit    = 1'b0;
    unique case (st)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.action)
            ACT_LOAD: begin
              wa = head.node;
              wd = head.value;
              if (CNT_W'(head.node) < cfg.ncount) begin
                we_a = 1'b1;
                we_b = 1'b1;
              end
              st_next = ST_PRB;
            end
            ACT_STEP: st_next = ST_NODE;
            ACT_READ: begin
              ra      = head.node;
              st_next = (CNT_W'(head.node) < cfg.ncount) ? ST_RDW : ST_PRB;
            end
            default: st_next = ST_PRB;
          endcase
        end
      end
      ST_RDW: st_next = ST_PRB;
      ST_PRB: begin
        ra      = cfg.probe;
        st_next = (CNT_W'(cfg.probe) < cfg.ncount) ? ST_PRW : ST_EMIT;
      end
      ST_PRW: st_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit    = 1'b1;
          st_next = ST_IDLE;
        end
      end
      ST_NODE: begin
        if (pinned) begin
          we_a    = cur_b;
          we_b    = !cur_b;
          st_next = ST_ADV;
        end else begin
          st_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        case (k)
          4'd1:    ra = xlo[ADDR_W-1:0];
          4'd2:    ra = xhi[ADDR_W-1:0];
          4'd3:    ra = ylo[ADDR_W-1:0];
          4'd4:    ra = yhi[ADDR_W-1:0];
          4'd5:    ra = zlo[ADDR_W-1:0];
          4'd6:    ra = zhi[ADDR_W-1:0];
          default: ra = idx;
        endcase
        if (k == 4'd8) st_next = ST_MUL;
      end
      ST_MUL: st_next = ST_ACC;
      ST_ACC: st_next = (ax == 2'd2) ? ST_WB : ST_MUL;
      ST_WB: begin
        wd      = nv_sat;
        we_a    = cur_b;
        we_b    = !cur_b;
        st_next = ST_ADV;
      end
      ST_ADV: st_next = last_node ? ST_SQR : ST_NODE;
      ST_SQR: st_next = ST_SQD;
      ST_SQD: st_next = ST_SQM;
      ST_SQM: st_next = ST_SQA;
      ST_SQA: st_next = last_node ? ST_PRB : ST_SQR;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_b     <= 1'b0;
      peak      <= '0;
      last_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (head_valid && head.action == ACT_LOAD &&
              CNT_W'(head.node) < cfg.ncount && vmag > peak)
            peak <= vmag;
        end
        ST_ADV: if (last_node) cur_b <= ~cur_b;
        ST_SQD: if (hmag > peak) peak <= hmag;
        ST_SQA: if (last_node) last_sum <= sum_w[64] ? '1 : sum_w[63:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        node_val <= '0;
        px       <= '0;
        py       <= '0;
        pz       <= '0;
        idx      <= '0;
        err      <= head_valid && (head.action == ACT_LOAD || head.action == ACT_READ) &&
                    CNT_W'(head.node) >= cfg.ncount;
      end
      ST_RDW: node_val <= cur_dout;
      ST_PRB: probe_val <= '0;
      ST_PRW: probe_val <= cur_dout;
      ST_NODE: begin
        k   <= '0;
        ax  <= '0;
        acc <= '0;
      end
      ST_FETCH: begin
        k <= k + 4'd1;
        if (k != 4'd0) nb[3'(k - 4'd1)] <= (k == 4'd8) ? nxt_dout : cur_dout;
      end
      ST_MUL: begin
        prod <= dmag * coef;
        neg  <= d[34];
      end
      ST_ACC: begin
        acc <= neg ? acc - 37'(r) : acc + 37'(r);
        ax  <= ax + 2'd1;
      end
      ST_ADV: begin
        if (last_node) begin
          idx <= '0;
          sum <= '0;
        end else begin
          idx <= idx + ADDR_W'(1);
          if (DIM_W'(px) == cfg.nx - DIM_W'(1)) begin
            px <= '0;
            if (DIM_W'(py) == cfg.ny - DIM_W'(1)) begin
              py <= '0;
              pz <= pz + POS_W'(1);
            end else begin
              py <= py + POS_W'(1);
            end
          end else begin
            px <= px + POS_W'(1);
          end
        end
      end
      ST_SQD: mag <= hmag;
      ST_SQM: sq <= 64'(mag) * 64'(mag);
      ST_SQA: begin
        sum <= sum_w[64] ? '1 : sum_w[63:0];
        idx <= idx + ADDR_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      probe_value <= probe_val;
      peak_abs    <= peak;
      sum_squares <= last_sum;
      node_value  <= node_val;
      error       <= err;
    end
  end

endmodule

### rtl/core/wave_leapfrog_stencil_3d_top.sv
// Load, read and unused action: a valid read passes RDW, then the probe is read in PRB
//   and, if it lies inside the grid, PRW, and EMIT registers the result.
// Step: an interior node passes NODE, FETCH, MUL and ACC per axis, WB and ADV; a pinned
//   node passes NODE and ADV; then SQR, SQD, SQM and SQA per node sum the squares.
// One item in work at a time; a two-entry input queue and an output register
//   let both channels keep moving meanwhile. One read port per field memory sets the pace.
// Synchronous active-high rst clears control, peak, sum and registers; fields stay undefined.
module wave_leapfrog_stencil_3d_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wls3d_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic [wls3d_pkg::ADDR_W-1:0]        node,
  input  logic signed [wls3d_pkg::WORD_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wls3d_pkg::WORD_W-1:0] probe_value,
  output logic [wls3d_pkg::WORD_W-1:0]        peak_abs,
  output logic [63:0]                         sum_squares,
  output logic signed [wls3d_pkg::WORD_W-1:0] node_value,
  output logic                                error
);
  import wls3d_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid, pop;

  // Register file: clamps dimensions and coefficients, derives strides and node count.
  wls3d_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Front: accept each transaction into a short queue.
  wls3d_front u_front (
    .clk, .rst, .in_valid, .in_ready, .action, .node, .value,
    .head_valid, .head, .pop
  );

  // Back: decode the action, sweep the stencil over both field memories on a step,
  // then read the probe and hold the result until the output transaction completes.
  wls3d_back u_back (
    .clk, .rst, .cfg, .head_valid, .head, .pop,
    .out_valid, .out_ready, .probe_value, .peak_abs, .sum_squares, .node_value, .error
  );

endmodule

### rtl/core/wls3d_checker.sv
`include "wave_leapfrog_stencil_3d_top_defines.svh"
module wls3d_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] peak_abs,
  input logic [63:0] sum_squares,
  input logic [31:0] node_value,
  input logic        error
);
  logic [31:0] last_peak;

  always_ff @(posedge clk) begin
    if (rst) last_peak <= '0;
    else if (out_valid && out_ready) last_peak <= peak_abs;
  end

  `WLS_ASSERT_IMPL(a_pready_high, 1'b1, pready)
  `WLS_ASSERT_IMPL(a_err_no_data, out_valid && error, node_value == 32'd0)
  `WLS_ASSERT_IMPL(a_peak_grows, out_valid, peak_abs >= last_peak)
  `WLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sum_squares))

endmodule

bind wave_leapfrog_stencil_3d_top wls3d_checker u_chk (.*);

### tb/sv/tb_wave_leapfrog_stencil_3d_top.sv
`timescale 1ns / 100ps

// Tracks the two pressure fields of the grid and predicts the status transaction
// that each accepted action returns.
class wave_grid_tracker;
  int               fld[2][4096];
  bit               cur_b;
  bit [31:0]        peak;
  bit [63:0]        last_sum;
  int unsigned      dx, dy, dz;
  bit [31:0]        cx, cy, cz;
  bit [11:0]        probe;
  bit [31:0]        exp_probe[$];
  bit [31:0]        exp_peak[$];
  bit [63:0]        exp_sum[$];
  bit [31:0]        exp_node[$];
  bit               exp_err[$];
  int               fails;
  int               n_loads, n_steps, n_reads, n_flagged;

  function new();
    cur_b = 0; peak = 0; last_sum = 0;
    dx = 16; dy = 16; dz = 16;
    cx = 0; cy = 0; cz = 0; probe = 0;
    fails = 0; n_loads = 0; n_steps = 0; n_reads = 0; n_flagged = 0;
  endfunction

  function int unsigned clamp_dim(bit [31:0] v);
    bit [4:0] d;
    d = v[4:0];
    if (d < 2) return 2;
    if (d > 16) return 16;
    return d;
  endfunction

  function void set_reg(wls3d_pkg::reg_t r, bit [31:0] v);
    bit [31:0] c;
    c = (v > 32'h8000_0000) ? 32'h8000_0000 : v;
    case (r)
      wls3d_pkg::REG_DIM_X:  dx = clamp_dim(v);
      wls3d_pkg::REG_DIM_Y:  dy = clamp_dim(v);
      wls3d_pkg::REG_DIM_Z:  dz = clamp_dim(v);
      wls3d_pkg::REG_COEF_X: cx = c;
      wls3d_pkg::REG_COEF_Y: cy = c;
      wls3d_pkg::REG_COEF_Z: cz = c;
      wls3d_pkg::REG_PROBE:  probe = v[11:0];
      default: ;
    endcase
  endfunction

  function int unsigned grid_nodes();
    return dx * dy * dz;
  endfunction

  function void raise_peak(longint v);
    bit [63:0] m;
    m = (v < 0) ? -v : v;
    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
    if (m[31:0] > peak) peak = m[31:0];
  endfunction

  // Round |d|*c/2^31 half away from zero; split keeps the product inside 64 bits.
  function longint weigh(longint d, bit [31:0] c);
    bit [63:0] m, mh, ml, lw, r;
    m  = (d < 0) ? -d : d;
    mh = m >> 32;
    ml = {32'd0, m[31:0]};
    lw = ml * {32'd0, c} + 64'h4000_0000;
    r  = mh * {32'd0, c} * 2 + (lw >> 31);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function longint axis_pull(int unsigned idx, int unsigned p, int unsigned n,
                             int unsigned stride, longint c, bit [31:0] cf);
    longint lo, hi;
    int unsigned other;
    if (n > 2) begin
      lo = fld[cur_b][idx - stride];
      hi = fld[cur_b][idx + stride];
    end else begin
      other = (p == 0) ? idx + stride : idx - stride;
      lo = fld[cur_b][other];
      hi = lo;
    end
    return weigh(lo + hi - 2 * c, cf);
  endfunction

  function void advance_grid();
    int unsigned idx;
    bit pinned;
    longint c, acc, v;
    bit [63:0] m, sq;
    bit [64:0] s;
    for (int unsigned z = 0; z < dz; z++)
      for (int unsigned y = 0; y < dy; y++)
        for (int unsigned x = 0; x < dx; x++) begin
          idx = x + dx * (y + dy * z);
          pinned = (dx > 2 && (x == 0 || x == dx - 1)) ||
                   (dy > 2 && (y == 0 || y == dy - 1)) ||
                   (dz > 2 && (z == 0 || z == dz - 1));
          if (pinned) begin
            fld[!cur_b][idx] = 0;
          end else begin
            c = fld[cur_b][idx];
            acc = axis_pull(idx, x, dx, 1, c, cx) + axis_pull(idx, y, dy, dx, c, cy) +
                  axis_pull(idx, z, dz, dx * dy, c, cz);
            v = 2 * c - longint'(fld[!cur_b][idx]) + acc;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            fld[!cur_b][idx] = int'(v);
          end
        end
    cur_b = !cur_b;
    last_sum = 0;
    for (int unsigned i = 0; i < grid_nodes(); i++) begin
      v = fld[cur_b][i];
      raise_peak(v);
      m = (v < 0) ? -v : v;
      sq = m * m;
      s = {1'b0, last_sum} + {1'b0, sq};
      last_sum = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    end
  endfunction

  function void note_item(logic [1:0] act, logic [11:0] nd, logic [31:0] val);
    bit [31:0] nv;
    bit [31:0] pv;
    bit err;
    nv = 0;
    err = 0;
    case (act)
      wls3d_pkg::ACT_LOAD: begin
        n_loads++;
        if (nd < grid_nodes()) begin
          fld[0][nd] = val;
          fld[1][nd] = val;
          raise_peak(longint'(signed'(val)));
        end else begin
          err = 1;
        end
      end
      wls3d_pkg::ACT_STEP: begin
        n_steps++;
        advance_grid();
      end
      wls3d_pkg::ACT_READ: begin
        n_reads++;
        if (nd < grid_nodes()) nv = fld[cur_b][nd];
        else err = 1;
      end
      default: ;
    endcase
    if (err) n_flagged++;
    pv = (probe < grid_nodes()) ? fld[cur_b][probe] : 32'd0;
    exp_probe = {exp_probe, pv};
    exp_peak = {exp_peak, peak};
    exp_sum = {exp_sum, last_sum};
    exp_node = {exp_node, nv};
    exp_err = {exp_err, err};
  endfunction

  function int pending();
    return exp_err.size();
  endfunction

  function void check_result(logic [31:0] pv, logic [31:0] pk, logic [63:0] ss,
                             logic [31:0] nv, logic er);
    bit [31:0] e_pv, e_pk, e_nv;
    bit [63:0] e_ss;
    bit e_er;
    if (pending() == 0) begin
      $error("status transaction arrived with nothing outstanding");
      fails++;
      return;
    end
    e_pv = exp_probe.pop_front();
    e_pk = exp_peak.pop_front();
    e_ss = exp_sum.pop_front();
    e_nv = exp_node.pop_front();
    e_er = exp_err.pop_front();
    if (pv !== e_pv) begin
      $error("probe_value: expected %0d, got %0d", $signed(e_pv), $signed(pv));
      fails++;
    end
    if (pk !== e_pk) begin
      $error("peak_abs: expected %0d, got %0d", e_pk, pk);
      fails++;
    end
    if (ss !== e_ss) begin
      $error("sum_squares: expected %0d, got %0d", e_ss, ss);
      fails++;
    end
    if (nv !== e_nv) begin
      $error("node_value: expected %0d, got %0d", $signed(e_nv), $signed(nv));
      fails++;
    end
    if (er !== e_er) begin
      $error("error: expected %0d, got %0d", e_er, er);
      fails++;
    end
  endfunction
endclass

module tb_wave_leapfrog_stencil_3d_top;
  import wls3d_pkg::*;

  // Action code with no function; the block must answer it with a plain status.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Worst phase is a 64-node grid stepped with stalls on both sides; this limit
  // leaves ample margin.
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [ADDR_W-1:0] node = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [WORD_W-1:0] probe_value;
  logic [WORD_W-1:0] peak_abs;
  logic [63:0] sum_squares;
  logic signed [WORD_W-1:0] node_value;
  logic        error;

  wave_grid_tracker grid = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_cycles = 0;
  int cycles = 0;

  wave_leapfrog_stencil_3d_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: count every cycle and abort on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check each accepted transaction, then pick next cycle's ready.
  // A pending hold-off forces ready low for its whole count.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        grid.check_result(probe_value, peak_abs, sum_squares, node_value, error);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one transaction, optionally after a random gap; return at its acceptance.
  task automatic push_item(input logic [1:0] act, input logic [11:0] nd,
                           input logic [31:0] val);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    node <= nd;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    grid.note_item(act, nd, val);
  endtask

  // Drop valid and hold until every outstanding status has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grid.pending() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input reg_t r, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    grid.set_reg(r, d);
    @(posedge clk);
  endtask

  // Half small Q16.16 values so steps stay in range; the other half are raw words.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(1)) return $urandom();
    return 32'($urandom_range(32'h3FFFF)) - 32'h20000;
  endfunction

  // Program a grid, then load the probe node first and every node after it, so
  // no status ever samples a node that was never written.
  task automatic set_grid(input logic [31:0] rx, input logic [31:0] ry,
                          input logic [31:0] rz, input logic [31:0] kx,
                          input logic [31:0] ky, input logic [31:0] kz,
                          input logic [11:0] pb);
    int unsigned n;
    reg_write(REG_DIM_X, rx);
    reg_write(REG_DIM_Y, ry);
    reg_write(REG_DIM_Z, rz);
    reg_write(REG_COEF_X, kx);
    reg_write(REG_COEF_Y, ky);
    reg_write(REG_COEF_Z, kz);
    reg_write(REG_PROBE, {20'd0, pb});
    n = grid.grid_nodes();
    if (pb < n) push_item(ACT_LOAD, pb, pick_value());
    for (int unsigned i = 0; i < n; i++) push_item(ACT_LOAD, 12'(i), pick_value());
  endtask

  // Random mix on a fully loaded grid: steps, reads, loads, bad nodes, unused code.
  task automatic random_mix(input int count);
    int unsigned n, r;
    n = grid.grid_nodes();
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 30)
        push_item(ACT_STEP, 12'($urandom()), pick_value());
      else if (r < 58)
        push_item(ACT_READ, 12'($urandom_range(n - 1)), pick_value());
      else if (r < 68)
        push_item(ACT_READ, 12'($urandom_range(4095, n)), pick_value());
      else if (r < 84)
        push_item(ACT_LOAD, 12'($urandom_range(n - 1)), pick_value());
      else if (r < 92)
        push_item(ACT_LOAD, 12'($urandom_range(4095, n)), pick_value());
      else
        push_item(ACT_UNUSED, 12'($urandom()), pick_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: 2x2x2 grid written with out-of-range X and Y dims, mirrored on every axis,
    // one coefficient above one, probe outside the grid.
    tx_idle_pct = 33;
    rx_idle_pct = 59;
    reg_write(REG_DIM_X, 32'd1);
    reg_write(REG_DIM_Y, 32'd0);
    reg_write(REG_DIM_Z, 32'd2);
    reg_write(REG_COEF_X, 32'hFFFF_FFFF);
    reg_write(REG_COEF_Y, 32'h8000_0000);
    reg_write(REG_COEF_Z, 32'h4000_0000);
    reg_write(REG_PROBE, 32'd4095);
    push_item(ACT_LOAD, 12'd0, 32'h7FFF_FFFF);
    push_item(ACT_LOAD, 12'd1, 32'h8000_0000);
    push_item(ACT_LOAD, 12'd2, 32'h0000_0000);
    push_item(ACT_LOAD, 12'd3, 32'hFFFF_FFFF);
    push_item(ACT_LOAD, 12'd4, 32'h0000_0001);
    push_item(ACT_LOAD, 12'd5, 32'h0001_0000);
    push_item(ACT_LOAD, 12'd6, 32'hFFFF_8000);
    push_item(ACT_LOAD, 12'd7, 32'h1234_5677);
    push_item(ACT_LOAD, 12'd8, 32'h5555_5555);
    push_item(ACT_LOAD, 12'd4095, 32'hAAAA_AAAA);
    push_item(ACT_READ, 12'd0, 32'd0);
    push_item(ACT_READ, 12'd1, 32'd0);
    push_item(ACT_READ, 12'd8, 32'd0);
    push_item(ACT_READ, 12'd4095, 32'd0);
    push_item(ACT_UNUSED, 12'd5, 32'hDEAD_BEEF);
    push_item(ACT_STEP, 12'd0, 32'd0);
    push_item(ACT_STEP, 12'hFFF, 32'd0);
    push_item(ACT_READ, 12'd1, 32'd0);
    push_item(ACT_READ, 12'd7, 32'd0);
    push_item(ACT_STEP, 12'd0, 32'd0);
    push_item(ACT_READ, 12'd4, 32'd0);
    drain();

    // 4x3x2: mixed pinned and mirrored axes, coefficients just above and below one and one near zero.
    tx_idle_pct = 59;
    rx_idle_pct = 33;
    set_grid(32'd4, 32'd3, 32'd2, 32'h8000_0001, 32'h7FFF_FFFF, 32'd1, 12'd5);
    random_mix(6);
    // Pause until every status is back, then keep going.
    drain();
    random_mix(6);
    drain();

    // 16x2x2 from dims above the maximum and below two; probe on the last node.
    // Stall the result side for a long stretch while loads keep coming.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_grid(32'd31, 32'd0, 32'd2, $urandom_range(32'h8000_0000),
             $urandom_range(32'h8000_0000), $urandom_range(32'h8000_0000), 12'd63);
    drain();
    hold_cycles = 400;
    repeat (10) push_item(ACT_LOAD, 12'($urandom_range(63)), pick_value());
    random_mix(8);
    drain();

    repeat (50) @(posedge clk);
    $display("Covered %0d loads, %0d grid steps and %0d reads (%0d flagged bad node)",
             grid.n_loads, grid.n_steps, grid.n_reads, grid.n_flagged);
    $display("over three grid shapes, including mirrored axes and saturating coefficients.");
    if (grid.fails == 0 && grid.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/wls3d_pkg.sv
rtl/core/wls3d_regs.sv
rtl/core/wls3d_front.sv
rtl/core/wls3d_back.sv
rtl/core/wave_leapfrog_stencil_3d_top.sv
rtl/core/wls3d_checker.sv
tb/sv/tb_wave_leapfrog_stencil_3d_top.sv
